// ===== src/nbq_pkg.sv =====
// Package for the notch biquad coefficient calculator.
// Holds shared constants, the controller state type and the command/status structs.
package nbq_pkg;

    localparam int FRAC_BITS_DEF    = 30;
    localparam int CORDIC_STEPS_DEF = 24;

    localparam logic [17:0] SR_RESET      = 18'd48000;
    localparam logic [31:0] HALF_PI_Q30   = 32'd1686629713;
    localparam logic [35:0] GAIN_INV_Q30  = 36'sd652032874;
    localparam logic [35:0] ONE_Q30       = 36'sd1073741824;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MOD,
        S_PDIV,
        S_ANGLE,
        S_CORDIC,
        S_QUAD,
        S_ADIV,
        S_ALPHA,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic mod_step;
        logic pdiv_step;
        logic angle;
        logic cordic_step;
        logic quad;
        logic adiv_step;
        logic alpha;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic mod_done;
        logic cordic_done;
        logic div_done;
        logic err;
    } t_status;

    function automatic logic [35:0] atan_q30(input logic [4:0] i);
        logic [35:0] v;
        case (i)
            5'd0:  v = 36'd843314857;
            5'd1:  v = 36'd497837829;
            5'd2:  v = 36'd263043837;
            5'd3:  v = 36'd133525159;
            5'd4:  v = 36'd67021687;
            5'd5:  v = 36'd33543516;
            5'd6:  v = 36'd16775851;
            5'd7:  v = 36'd8388437;
            5'd8:  v = 36'd4194283;
            5'd9:  v = 36'd2097149;
            5'd31: v = 36'd0;
            default: v = 36'd1 << (30 - i);
        endcase
        return v;
    endfunction

endpackage

// ===== src/nbq_ctrl.sv =====
// Controller state machine for the notch coefficient calculator.
// Depends on nbq_pkg; drives the datapath through t_cmd and reads t_status.
module nbq_ctrl import nbq_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_accept,
    input  logic    i_out_free,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy,
    output logic    o_done
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        o_done  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_in_accept) begin
                    o_cmd.load = 1'b1;
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                if (i_status.err) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.mod_step = 1'b1;
                    if (i_status.mod_done) n_state = S_PDIV;
                end
            end
            S_PDIV: begin
                o_cmd.pdiv_step = 1'b1;
                if (i_status.div_done) n_state = S_ANGLE;
            end
            S_ANGLE: begin
                o_cmd.angle = 1'b1;
                n_state = S_CORDIC;
            end
            S_CORDIC: begin
                o_cmd.cordic_step = 1'b1;
                if (i_status.cordic_done) n_state = S_QUAD;
            end
            S_QUAD: begin
                o_cmd.quad = 1'b1;
                n_state = S_ADIV;
            end
            S_ADIV: begin
                o_cmd.adiv_step = 1'b1;
                if (i_status.div_done) n_state = S_ALPHA;
            end
            S_ALPHA: begin
                o_cmd.alpha = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_cmd.finish = 1'b1;
                    o_done = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== src/nbq_datapath.sv =====
// Datapath: modulo, phase division, angle scaling, CORDIC, alpha division, output rounding.
// Depends on nbq_pkg; sequenced by nbq_ctrl through t_cmd.
module nbq_datapath import nbq_pkg::*; #(
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic [17:0]        i_fs,
    input  logic [17:0]        i_freq,
    input  logic [15:0]        i_q,
    output t_status            o_status,
    output logic signed [31:0] o_a0,
    output logic signed [31:0] o_a1,
    output logic signed [31:0] o_a2,
    output logic signed [31:0] o_b0,
    output logic               o_err
);

    localparam int SH = 30 - FRAC_BITS;
    localparam int CW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

    logic [17:0] r_fs;
    logic [15:0] r_q;
    logic        r_err;
    logic [17:0] r_mod;
    logic [4:0]  r_mcnt;
    logic [35:0] r_fsh;
    // Restoring divider shared by the phase and alpha divisions. The dividend
    // shifts out of the top of r_dvd while quotient bits enter at the bottom.
    logic [17:0] r_rem;
    logic [37:0] r_dvd;
    logic [5:0]  r_dcnt;
    logic [35:0] r_z, r_x, r_y;
    logic [CW:0] r_ccnt;
    logic [1:0]  r_quad;
    logic [35:0] r_c;
    logic        r_sneg;
    logic [31:0] r_a0, r_a1, r_a2, r_b0;

    logic        mod_ge;
    logic [17:0] mod_nx;
    assign mod_ge = {18'd0, r_mod} >= r_fsh;
    assign mod_nx = mod_ge ? r_mod - r_fsh[17:0] : r_mod;

    logic [17:0] div_den;
    logic [18:0] div_trial;
    logic        div_ge;
    assign div_den   = i_cmd.pdiv_step ? r_fs : {2'd0, r_q};
    assign div_trial = {r_rem, r_dvd[37]};
    assign div_ge    = div_trial >= {1'b0, div_den};

    logic [60:0] ang_prod;
    assign ang_prod = 61'(r_dvd[29:0]) * 61'(HALF_PI_Q30) + 61'd536870912;

    logic [35:0] dx, dy;
    logic [4:0]  cidx;
    assign cidx = 5'(r_ccnt);
    assign dx = 36'($signed(r_y) >>> cidx);
    assign dy = 36'($signed(r_x) >>> cidx);

    logic [35:0] c_sel, s_sel, s_mag;
    always_comb begin
        case (r_quad)
            2'd0:    begin c_sel = r_x;  s_sel = r_y;  end
            2'd1:    begin c_sel = -r_y; s_sel = r_x;  end
            2'd2:    begin c_sel = -r_x; s_sel = -r_y; end
            default: begin c_sel = r_y;  s_sel = -r_x; end
        endcase
    end
    assign s_mag = s_sel[35] ? -s_sel : s_sel;

    function automatic logic [31:0] to_out(input logic signed [39:0] v);
        logic signed [39:0] t;
        t = v;
        if (SH > 0) t = (v + (40'sd1 <<< (SH > 0 ? SH - 1 : 0))) >>> SH;
        if (t > 40'sd2147483647)       return 32'h7fffffff;
        else if (t < -40'sd2147483648) return 32'h80000000;
        return t[31:0];
    endfunction

    logic signed [39:0] alpha;
    assign alpha = r_sneg ? -40'(r_dvd) : 40'(r_dvd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err <= 1'b0;
        end else if (i_cmd.load) begin
            r_err <= (i_q == 16'd0) || (i_fs == 18'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_fs   <= i_fs;
            r_q    <= i_q;
            r_mod  <= i_freq;
            r_mcnt <= 5'd0;
            r_fsh  <= {1'b0, i_fs, 17'd0};
            r_a0   <= '0;
            r_a1   <= '0;
            r_a2   <= '0;
            r_b0   <= '0;
        end else if (i_cmd.mod_step) begin
            r_mod  <= mod_nx;
            r_fsh  <= r_fsh >> 1;
            r_mcnt <= r_mcnt + 5'd1;
            // The remainder seeds the phase division, whose dividend is it times 2^32.
            if (r_mcnt == 5'd17) begin
                r_rem  <= mod_nx;
                r_dvd  <= '0;
                r_dcnt <= 6'd0;
            end
        end else if (i_cmd.pdiv_step || i_cmd.adiv_step) begin
            if (div_ge) begin
                r_rem <= 18'(div_trial - {1'b0, div_den});
            end else begin
                r_rem <= div_trial[17:0];
            end
            r_dvd  <= {r_dvd[36:0], div_ge};
            r_dcnt <= r_dcnt + 6'd1;
        end else if (i_cmd.angle) begin
            r_quad <= r_dvd[31:30];
            r_z    <= 36'(ang_prod >> 30);
            r_ccnt <= '0;
            r_x    <= GAIN_INV_Q30;
            r_y    <= '0;
        end else if (i_cmd.cordic_step) begin
            if (!r_z[35]) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - atan_q30(cidx);
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + atan_q30(cidx);
            end
            r_ccnt <= r_ccnt + (CW+1)'(1);
        end else if (i_cmd.quad) begin
            // Alpha division: (|sin| * 128 + Q/2) / Q, sign applied afterwards.
            r_c    <= c_sel;
            r_sneg <= s_sel[35];
            r_rem  <= '0;
            r_dvd  <= {s_mag[30:0], 7'd0} + {23'd0, r_q[15:1]};
            r_dcnt <= 6'd0;
        end else if (i_cmd.alpha) begin
            r_a0 <= to_out($signed(40'(ONE_Q30)) + alpha);
            r_a1 <= to_out(-(40'(signed'(r_c)) <<< 1));
            r_a2 <= to_out($signed(40'(ONE_Q30)) - alpha);
            r_b0 <= to_out($signed(40'(ONE_Q30)));
        end
    end

    assign o_status.mod_done    = i_cmd.mod_step && (r_mcnt == 5'd17);
    assign o_status.cordic_done = i_cmd.cordic_step &&
                                  (r_ccnt == (CW+1)'(CORDIC_STEPS - 1));
    assign o_status.div_done    = (i_cmd.pdiv_step && (r_dcnt == 6'd31)) ||
                                  (i_cmd.adiv_step && (r_dcnt == 6'd37));
    assign o_status.err         = r_err;

    assign o_a0  = r_err ? '0 : r_a0;
    assign o_a1  = r_err ? '0 : r_a1;
    assign o_a2  = r_err ? '0 : r_a2;
    assign o_b0  = r_err ? '0 : r_b0;
    assign o_err = r_err;

    logic unused;
    assign unused = ^{i_cmd.finish, s_mag[35:31], ang_prod[29:0]};

endmodule

// ===== src/notch_biquad_coeff_calc.sv =====
// Notch biquad coefficient calculator. One request is taken at a time. A valid
// request passes through an 18-step modulo, a 32-step restoring phase division,
// angle scaling, CORDIC_STEPS (24) rotation steps, quadrant selection, a 38-step
// restoring alpha division, rounding and output; the next request can be taken
// once the result is in the output register. A zero Q or zero sample rate skips
// the arithmetic and goes straight to output. A result held by the output stall
// keeps the next one waiting in its final step. The sample rate register is
// written through its own valid/ready port while the block is idle and no
// result is pending.
module notch_biquad_coeff_calc import nbq_pkg::*; #(
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [17:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [17:0]        i_centre_freq_hz,
    input  logic [15:0]        i_quality_factor,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_coef_a0,
    output logic signed [31:0] o_coef_a1,
    output logic signed [31:0] o_coef_a2,
    output logic signed [31:0] o_coef_b0,
    output logic signed [31:0] o_coef_b1,
    output logic signed [31:0] o_coef_b2,
    output logic               o_calc_error
);

    logic [17:0] r_fs;
    t_cmd        cmd;
    t_status     status;
    logic        busy, done, accept;
    logic        r_valid;
    logic signed [31:0] a0, a1, a2, b0;
    logic        err;
    logic signed [31:0] r_coef_a0, r_coef_a1, r_coef_a2;
    logic signed [31:0] r_coef_b0, r_coef_b1, r_coef_b2;
    logic        r_calc_error;

    assign accept      = i_valid && !o_stall;
    assign o_stall     = busy;
    assign o_cfg_ready = !busy && !r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fs <= SR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_fs <= i_cfg_data;
        end
    end

    nbq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_accept(accept),
        .i_out_free (!r_valid || !i_stall),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_busy     (busy),
        .o_done     (done)
    );

    nbq_datapath #(
        .FRAC_BITS   (FRAC_BITS),
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_fs    (r_fs),
        .i_freq  (i_centre_freq_hz),
        .i_q     (i_quality_factor),
        .o_status(status),
        .o_a0    (a0),
        .o_a1    (a1),
        .o_a2    (a2),
        .o_b0    (b0),
        .o_err   (err)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (done) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_coef_a0    <= a0;
            r_coef_a1    <= a1;
            r_coef_a2    <= a2;
            r_coef_b0    <= b0;
            r_coef_b1    <= a1;
            r_coef_b2    <= b0;
            r_calc_error <= err;
        end
    end

    assign o_valid      = r_valid;
    assign o_coef_a0    = r_coef_a0;
    assign o_coef_a1    = r_coef_a1;
    assign o_coef_a2    = r_coef_a2;
    assign o_coef_b0    = r_coef_b0;
    assign o_coef_b1    = r_coef_b1;
    assign o_coef_b2    = r_coef_b2;
    assign o_calc_error = r_calc_error;

endmodule

// ===== src/nbq_checker.sv =====
// Port-level checker for the notch coefficient calculator.
// Depends on nothing but the top level's ports; bound at the end of this file.
module nbq_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic               o_cfg_ready,
    input logic               o_calc_error,
    input logic signed [31:0] o_coef_b0,
    input logic signed [31:0] o_coef_a0
);

    // An output held while stalled keeps its flag.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // No new request is taken in the cycle right after one was taken.
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second request taken while busy");

    // An error result carries zero a0 and b0 coefficients.
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_calc_error |-> o_coef_b0 == 32'sd0 && o_coef_a0 == 32'sd0)
        else $error("error result with nonzero coefficients");

    // Configuration is refused while a request is being worked.
    a_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> !o_cfg_ready)
        else $error("configuration open while busy");

endmodule

bind notch_biquad_coeff_calc nbq_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_cfg_ready (o_cfg_ready),
    .o_calc_error(o_calc_error),
    .o_coef_b0   (o_coef_b0),
    .o_coef_a0   (o_coef_a0)
);
